// ===== rtl/ic3_pkg.sv =====
package ic3_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int KERNEL_SIZE   = 3;
    localparam int KERNEL_TAPS   = KERNEL_SIZE * KERNEL_SIZE;

    localparam int CFG_DW  = 48;
    localparam int CFG_IW  = 3;
    localparam int PIX_W   = 8;
    // Accumulator holds nine 8x8 products plus the 17-bit offset with margin.
    localparam int ACC_W   = 21;

    localparam logic [CFG_IW-1:0] REG_COEF_TOP = 3'd0;
    localparam logic [CFG_IW-1:0] REG_COEF_BOT = 3'd1;
    localparam logic [CFG_IW-1:0] REG_OFFSET   = 3'd2;
    localparam logic [CFG_IW-1:0] REG_DIVISOR  = 3'd3;
    localparam logic [CFG_IW-1:0] REG_WIDTH    = 3'd4;
    localparam logic [CFG_IW-1:0] REG_HEIGHT   = 3'd5;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic read;
        logic update;
        logic mac_step;
        logic div_load;
        logic div_step;
        logic div_finish;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic has_result;
        logic interior;
        logic is_drain;
        logic mac_last;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/ic3_ctrl.sv =====
module ic3_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  ic3_pkg::t_status i_status,
    output ic3_pkg::t_cmd    o_cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_READ   = 4'd2;
    localparam logic [3:0] S_UPDATE = 4'd3;
    localparam logic [3:0] S_MAC    = 4'd4;
    localparam logic [3:0] S_DLOAD  = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_DFIN   = 4'd7;
    localparam logic [3:0] S_PUSH   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                if (!i_status.has_result) begin
                    n_state = S_IDLE;
                end else if (!i_status.is_drain && i_status.interior) begin
                    n_state = S_MAC;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_MAC: begin
                o_cmd.mac_step = 1'b1;
                if (i_status.mac_last) begin
                    n_state = S_DLOAD;
                end
            end
            S_DLOAD: begin
                o_cmd.div_load = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_DFIN;
                end
            end
            S_DFIN: begin
                o_cmd.div_finish = 1'b1;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/ic3_dp.sv =====
module ic3_dp #(
    parameter int MAX_WIDTH = ic3_pkg::DEF_MAX_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ic3_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  logic [ic3_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic [ic3_pkg::PIX_W-1:0]   i_s_tdata,
    input  logic [0:0]                  i_s_tuser,
    input  ic3_pkg::t_cmd               i_cmd,
    output ic3_pkg::t_status            o_status,
    output logic [ic3_pkg::PIX_W-1:0]   o_m_tdata,
    output logic                        o_m_tlast,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int PW    = $clog2(MAX_WIDTH + 2);
    localparam int PX    = ic3_pkg::PIX_W;
    localparam int ACC_W = ic3_pkg::ACC_W;
    localparam int TAPS  = ic3_pkg::KERNEL_TAPS;
    localparam int KW    = $clog2(TAPS);
    localparam int DVD_W = ACC_W - 1;
    localparam int DCW   = $clog2(DVD_W);

    // Configuration registers.
    logic [47:0]        r_coef_top;
    logic [23:0]        r_coef_bot;
    logic signed [16:0] r_offset;
    logic [7:0]         r_divisor;
    logic [10:0]        r_width;
    logic [15:0]        r_height;

    // Frame position and window.
    logic [AW-1:0]      r_col;
    logic [15:0]        r_row;
    logic [PW-1:0]      r_pend;
    logic [PX-1:0]      r_win [TAPS];
    logic [AW-1:0]      r_clr_addr;
    logic               r_ovalid;

    // Line stores.
    logic [PX-1:0]      r_mem_up [MAX_WIDTH];
    logic [PX-1:0]      r_mem_lo [MAX_WIDTH];
    logic [PX-1:0]      r_rd_up;
    logic [PX-1:0]      r_rd_lo;

    // Item and arithmetic.
    logic               r_op;
    logic [PX-1:0]      r_px;
    logic signed [ACC_W-1:0] r_acc;
    logic [KW-1:0]      r_k;
    logic [DVD_W-1:0]   r_dvd;
    logic [7:0]         r_rem;
    logic [DCW-1:0]     r_dcnt;
    logic               r_neg;
    logic [PX-1:0]      r_res;
    logic               r_last;
    logic [PX-1:0]      r_odata;
    logic               r_olast;

    logic [CW-1:0]      w_eff;
    logic [15:0]        h_eff;
    logic [AW-1:0]      c_eff;
    logic [CW-1:0]      c_inc;
    logic               pix_result;
    logic               drain_ok;
    logic [AW-1:0]      rd_addr_up;
    logic [AW-1:0]      rd_addr_lo;
    logic               mem_we;
    logic [AW-1:0]      wr_addr;
    logic [PX-1:0]      wd_up;
    logic [PX-1:0]      wd_lo;
    logic [71:0]        coefs;
    logic signed [7:0]  wgt;
    logic signed [PX:0] tap;
    logic signed [16:0] prod;
    logic [8:0]         trial;
    logic               trial_ge;
    logic [7:0]         d_eff;

    always_comb begin
        if (r_width == 11'd0) begin
            w_eff = CW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(r_width);
        end
    end

    assign h_eff = (r_height == 16'd0) ? 16'd1 : r_height;
    assign c_eff = (CW'(r_col) >= w_eff) ? '0 : r_col;
    assign c_inc = CW'(c_eff) + CW'(1);
    assign d_eff = (r_divisor == 8'd0) ? 8'd1 : r_divisor;

    assign pix_result = (r_pend > PW'(w_eff));
    assign drain_ok   = (r_row >= h_eff) && (r_pend != '0)
                        && (r_pend <= PW'(w_eff) + PW'(1));

    assign rd_addr_up = (r_op == ic3_pkg::OP_DRAIN) ? AW'(w_eff - CW'(1)) : c_eff;
    assign rd_addr_lo = (r_op == ic3_pkg::OP_DRAIN) ? AW'(w_eff - CW'(r_pend)) : c_eff;

    assign mem_we  = i_cmd.clear_step || (i_cmd.update && r_op == ic3_pkg::OP_PIXEL);
    assign wr_addr = i_cmd.clear_step ? r_clr_addr : c_eff;
    assign wd_up   = i_cmd.clear_step ? '0 : r_rd_lo;
    assign wd_lo   = i_cmd.clear_step ? '0 : r_px;

    // Flipped kernel: weight k meets window tap 8-k.
    assign coefs = {r_coef_bot, r_coef_top};
    assign wgt   = $signed(coefs[r_k*8 +: 8]);
    assign tap   = $signed({1'b0, r_win[KW'(TAPS-1) - r_k]});
    assign prod  = wgt * tap;

    assign trial    = {r_rem, r_dvd[DVD_W-1]};
    assign trial_ge = (trial >= {1'b0, d_eff});

    assign o_status.clear_last = (r_clr_addr == AW'(MAX_WIDTH - 1));
    assign o_status.has_result = (r_op == ic3_pkg::OP_DRAIN) ? drain_ok : pix_result;
    assign o_status.interior   = (c_eff >= AW'(2)) && (r_row >= 16'd2)
                                 && (w_eff >= CW'(3)) && (h_eff >= 16'd3);
    assign o_status.is_drain   = (r_op == ic3_pkg::OP_DRAIN);
    assign o_status.mac_last   = (r_k == KW'(TAPS-1));
    assign o_status.div_last   = (r_dcnt == DCW'(DVD_W-1));
    assign o_status.out_free   = !r_ovalid || i_m_tready;

    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;
    assign o_m_tvalid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_up[wr_addr] <= wd_up;
            r_mem_lo[wr_addr] <= wd_lo;
        end
        if (i_cmd.read) begin
            r_rd_up <= r_mem_up[rd_addr_up];
            r_rd_lo <= r_mem_lo[rd_addr_lo];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_top <= 48'h0001_0000_0000;
            r_coef_bot <= '0;
            r_offset   <= '0;
            r_divisor  <= 8'd1;
            r_width    <= 11'd1024;
            r_height   <= 16'd1024;
            r_col      <= '0;
            r_row      <= '0;
            r_pend     <= '0;
            r_clr_addr <= '0;
            r_ovalid   <= 1'b0;
            for (int i = 0; i < TAPS; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (i_cmd.clear_step) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.capture && i_s_tuser[0] == ic3_pkg::OP_PIXEL && r_row >= h_eff) begin
                r_col  <= '0;
                r_row  <= '0;
                r_pend <= '0;
            end
            if (i_cmd.update) begin
                if (r_op == ic3_pkg::OP_PIXEL) begin
                    for (int a = 0; a < 3; a++) begin
                        r_win[a*3]     <= r_win[a*3 + 1];
                        r_win[a*3 + 1] <= r_win[a*3 + 2];
                    end
                    r_win[2] <= r_rd_up;
                    r_win[5] <= r_rd_lo;
                    r_win[8] <= r_px;
                    if (c_inc >= w_eff) begin
                        r_col <= '0;
                        r_row <= r_row + 16'd1;
                    end else begin
                        r_col <= AW'(c_inc);
                    end
                    if (!pix_result) begin
                        r_pend <= r_pend + PW'(1);
                    end
                end else if (drain_ok) begin
                    r_pend <= r_pend - PW'(1);
                end
            end
            if (i_cmd.push) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            // Geometry writes restart the frame; the line stores are kept.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ic3_pkg::REG_COEF_TOP: r_coef_top <= i_cfg_data;
                    ic3_pkg::REG_COEF_BOT: r_coef_bot <= i_cfg_data[23:0];
                    ic3_pkg::REG_OFFSET:   r_offset   <= $signed(i_cfg_data[16:0]);
                    ic3_pkg::REG_DIVISOR:  r_divisor  <= i_cfg_data[7:0];
                    ic3_pkg::REG_WIDTH: begin
                        r_width <= i_cfg_data[10:0];
                        r_col   <= '0;
                        r_row   <= '0;
                        r_pend  <= '0;
                    end
                    ic3_pkg::REG_HEIGHT: begin
                        r_height <= i_cfg_data[15:0];
                        r_col    <= '0;
                        r_row    <= '0;
                        r_pend   <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_s_tuser[0];
            r_px <= i_s_tdata;
        end
        if (i_cmd.update) begin
            r_acc <= ACC_W'(r_offset);
            r_k   <= '0;
            if (r_op == ic3_pkg::OP_PIXEL) begin
                r_res  <= r_win[5];
                r_last <= 1'b0;
            end else begin
                r_res  <= (r_pend == PW'(w_eff) + PW'(1)) ? r_rd_up : r_rd_lo;
                r_last <= (r_pend == PW'(1));
            end
        end
        if (i_cmd.mac_step) begin
            r_acc <= r_acc + ACC_W'(prod);
            r_k   <= r_k + KW'(1);
        end
        if (i_cmd.div_load) begin
            r_neg  <= r_acc[ACC_W-1];
            r_dvd  <= r_acc[DVD_W-1:0];
            r_rem  <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= trial_ge ? 8'(trial - {1'b0, d_eff}) : trial[7:0];
            r_dvd  <= {r_dvd[DVD_W-2:0], trial_ge};
            r_dcnt <= r_dcnt + DCW'(1);
        end
        // A negative sum truncates to zero or below, which clips to zero.
        if (i_cmd.div_finish) begin
            if (r_neg) begin
                r_res <= '0;
            end else if (|r_dvd[DVD_W-1:PX]) begin
                r_res <= '1;
            end else begin
                r_res <= r_dvd[PX-1:0];
            end
        end
        if (i_cmd.push) begin
            r_odata <= r_res;
            r_olast <= r_last;
        end
    end

endmodule

// ===== rtl/image_convolution_3x3.sv =====
// 3x3 convolution filter for an 8-bit raster pixel stream. Each request carries one pixel
// (tuser low) or a drain marker (tuser high); results come out one row and one column behind
// the input, border pixels unchanged, interior pixels convolved with the flipped kernel,
// offset added, divided toward zero and clipped to 0..255. After the last pixel of a frame,
// drain requests flush the remaining width+1 results, the final one flagged with tlast.
// Requests are handled one at a time: each is captured in idle, then read and update follow;
// a border pixel or drain with a result then goes to push, an interior pixel first passes
// the nine-step multiply-accumulate through one shared multiplier and the 20-step restoring
// divider. Push waits until the output register is free, then the controller is idle again.
// A finished result waits in the output register while the next request is taken. After
// reset both line stores are cleared over all MAX_WIDTH entries; no request is accepted
// meanwhile. Configuration is written through a simple write port, by the user only while
// the filter is idle, unchecked by the block; a width or height write restarts the frame.
module image_convolution_3x3 #(
    parameter int MAX_WIDTH = ic3_pkg::DEF_MAX_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write port.
    input  logic                        i_cfg_we,
    input  logic [ic3_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  logic [ic3_pkg::CFG_DW-1:0]  i_cfg_data,
    // Input stream.
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [ic3_pkg::PIX_W-1:0]   i_s_tdata,   // [7:0] pixel_in
    input  logic [0:0]                  i_s_tuser,   // [0] operation (drain when high)
    // Output stream.
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [ic3_pkg::PIX_W-1:0]   o_m_tdata,   // [7:0] pixel_out
    output logic                        o_m_tlast    // last_of_frame
);

    ic3_pkg::t_cmd    cmd;
    ic3_pkg::t_status status;

    // The controller sequences each request; the datapath holds the stores and arithmetic.
    ic3_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ic3_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready)
    );

endmodule

// ===== tb/sv/tb_image_convolution_3x3.sv =====
`timescale 1ns / 100ps

module tb_image_convolution_3x3;

    localparam int  MAXW        = ic3_pkg::DEF_MAX_WIDTH;
    localparam int  SETTLE      = 60;       // longer than the slowest request
    localparam int  CYCLE_LIMIT = 4000000;

    // A filtered pixel as it is expected on the output stream.
    typedef struct {
        logic [7:0] pix;
        logic       last;
    } t_result;

    // One row of the directed table. Where fixed is set, the expected result is typed in
    // (or its absence, when has_res is clear); other rows are checked against the predictor.
    typedef struct {
        logic       op;
        logic [7:0] pix;
        bit         fixed;
        bit         has_res;
        logic [7:0] res_pix;
        logic       res_last;
    } t_row;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [ic3_pkg::CFG_IW-1:0]   i_cfg_idx;
    logic [ic3_pkg::CFG_DW-1:0]   i_cfg_data;
    logic                         i_s_tvalid;
    logic                         o_s_tready;
    logic [ic3_pkg::PIX_W-1:0]    i_s_tdata;   // [7:0] pixel_in
    logic [0:0]                   i_s_tuser;   // [0] operation
    logic                         o_m_tvalid;
    logic                         i_m_tready;
    logic [ic3_pkg::PIX_W-1:0]    o_m_tdata;   // [7:0] pixel_out
    logic                         o_m_tlast;   // last_of_frame

    image_convolution_3x3 DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // ------------------------------------------------------------------------------------
    // Predictor state: its own copy of the line stores, the window, the frame position and
    // the register file.
    // ------------------------------------------------------------------------------------
    logic [7:0]  row_above [MAXW];
    logic [7:0]  row_below [MAXW];
    logic [7:0]  window [9];
    int          col_pos;
    int          row_pos;
    int          backlog;

    logic [47:0] w_top;
    logic [23:0] w_bot;
    logic [16:0] offset;
    logic [7:0]  div;
    logic [10:0] width;
    logic [15:0] height;

    t_result     filtered_q[$];
    int          fails;
    int          sent;
    bit          steady_in;    // when set the sender never idles
    bit          steady_out;   // when set the receiver never stalls
    int          cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The run is cut off if it takes far longer than even the slowest correct run would.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("%0t: timeout with %0d results outstanding", $time, filtered_q.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic int eff_w();
        if (width == 0) return 1;
        if (width > MAXW) return MAXW;
        return int'(width);
    endfunction

    function automatic int eff_h();
        return height == 0 ? 1 : int'(height);
    endfunction

    // Weight k of the kernel, row k/3 and column k%3, as a signed byte.
    function automatic int tap(int k);
        logic [7:0] b;
        b = k < 6 ? w_top[8*k +: 8] : w_bot[8*(k-6) +: 8];
        return int'($signed(b));
    endfunction

    // True convolution: the kernel is applied flipped in both axes over the window.
    function automatic logic [7:0] filter_window();
        int sum;
        int d;
        sum = 0;
        d = div == 0 ? 1 : int'(div);
        for (int m = 0; m < 3; m++)
            for (int n = 0; n < 3; n++)
                sum += tap(3*m + n) * int'(window[(2-m)*3 + (2-n)]);
        sum = (sum + int'($signed(offset))) / d;
        if (sum < 0) sum = 0;
        if (sum > 255) sum = 255;
        return sum[7:0];
    endfunction

    // Advances the predicted state by one accepted request and says whether it yields a
    // result, and which one.
    function automatic bit filter_step(logic op, logic [7:0] px, output t_result res);
        int w, h, c, r, pr, pc;
        logic [7:0] up, lo;
        w = eff_w();
        h = eff_h();
        res.pix  = '0;
        res.last = 1'b0;
        if (op == ic3_pkg::OP_DRAIN) begin
            // Nothing to flush before the frame is complete or once it is flushed.
            if (row_pos < h || backlog == 0 || backlog > w + 1) return 0;
            res.pix  = backlog == w + 1 ? row_above[w-1] : row_below[w-backlog];
            res.last = backlog == 1;
            backlog--;
            return 1;
        end
        // A pixel after the last one of a frame opens the next frame and drops the backlog.
        if (row_pos >= h) begin
            row_pos = 0;
            col_pos = 0;
            backlog = 0;
        end
        c = col_pos >= w ? 0 : col_pos;
        r = row_pos;
        up = row_above[c];
        lo = row_below[c];
        row_above[c] = lo;
        row_below[c] = px;
        for (int a = 0; a < 3; a++) begin
            window[a*3]     = window[a*3 + 1];
            window[a*3 + 1] = window[a*3 + 2];
        end
        window[2] = up;
        window[5] = lo;
        window[8] = px;
        // The centre of the window lies one row and one column behind the new pixel.
        if (c >= 1) begin
            pr = r - 1;
            pc = c - 1;
        end else begin
            pr = r - 2;
            pc = w - 1;
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
        end
        col_pos = c;
        row_pos = r;
        backlog++;
        if (backlog <= w + 1) return 0;
        backlog--;
        if (w >= 3 && h >= 3 && pr >= 1 && pr <= h - 2 && pc >= 1 && pc <= w - 2)
            res.pix = filter_window();
        else
            res.pix = window[4];
        return 1;
    endfunction

    // Sender idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drives one request and waits for it to be accepted. Expectations come from the
    // predictor, or from the typed values of a fixed directed row.
    task automatic send_request(t_row row);
        int g;
        t_result res;
        bit has;
        g = steady_in ? 0 : pick_gap();
        @(negedge i_clk);
        if (g > 0) begin
            i_s_tvalid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = row.pix;
        i_s_tuser  = row.op;
        do @(posedge i_clk); while (!o_s_tready);
        sent++;
        has = filter_step(row.op, row.pix, res);
        if (row.fixed) begin
            has      = row.has_res;
            res.pix  = row.res_pix;
            res.last = row.res_last;
        end
        if (has) filtered_q.push_back(res);
    endtask

    task automatic send_pixel(logic [7:0] px);
        t_row row;
        row = '{ic3_pkg::OP_PIXEL, px, 0, 0, 8'd0, 1'b0};
        send_request(row);
    endtask

    task automatic send_drain();
        t_row row;
        row = '{ic3_pkg::OP_DRAIN, 8'($urandom_range(0, 255)), 0, 0, 8'd0, 1'b0};
        send_request(row);
    endtask

    // Holds the input side until every expected result has been taken, then lets the block
    // finish any request that yields no result.
    task automatic wait_idle();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Register write; the predictor takes the same value. Geometry writes restart the frame.
    task automatic write_reg(logic [ic3_pkg::CFG_IW-1:0] idx, logic [47:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            ic3_pkg::REG_COEF_TOP: w_top  = value[47:0];
            ic3_pkg::REG_COEF_BOT: w_bot  = value[23:0];
            ic3_pkg::REG_OFFSET:   offset = value[16:0];
            ic3_pkg::REG_DIVISOR:  div    = value[7:0];
            ic3_pkg::REG_WIDTH, ic3_pkg::REG_HEIGHT: begin
                if (idx == ic3_pkg::REG_WIDTH) width = value[10:0];
                else height = value[15:0];
                col_pos = 0;
                row_pos = 0;
                backlog = 0;
            end
            default: ;
        endcase
    endtask

    // Pixel values lean towards the extremes so that clipping and sign paths are exercised.
    function automatic logic [7:0] pick_pixel();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return 8'd0;
        if (p == 1) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_weight();
        int p;
        p = $urandom_range(0, 7);
        if (p == 0) return 8'h80;
        if (p == 1) return 8'h7f;
        if (p < 5) return 8'($urandom_range(0, 6) - 3);
        return 8'($urandom_range(0, 255));
    endfunction

    // Chooses filter settings for a phase: two extremes, one fixed mix, then random.
    task automatic set_filter(int style);
        logic [47:0] top;
        logic [23:0] bot;
        case (style)
            0: begin
                write_reg(ic3_pkg::REG_COEF_TOP, {6{8'h80}});
                write_reg(ic3_pkg::REG_COEF_BOT, 48'({3{8'h80}}));
                write_reg(ic3_pkg::REG_OFFSET, 48'(17'h10000));
                write_reg(ic3_pkg::REG_DIVISOR, 48'd1);
            end
            1: begin
                write_reg(ic3_pkg::REG_COEF_TOP, {6{8'h7f}});
                write_reg(ic3_pkg::REG_COEF_BOT, 48'({3{8'h7f}}));
                write_reg(ic3_pkg::REG_OFFSET, 48'(17'h0ffff));
                write_reg(ic3_pkg::REG_DIVISOR, 48'd255);
            end
            2: begin
                // A zero divisor behaves as one.
                write_reg(ic3_pkg::REG_COEF_TOP, 48'h0000_ff00_0001);
                write_reg(ic3_pkg::REG_COEF_BOT, 48'(24'hff_0000));
                write_reg(ic3_pkg::REG_OFFSET, 48'd128);
                write_reg(ic3_pkg::REG_DIVISOR, 48'd0);
            end
            default: begin
                for (int k = 0; k < 6; k++) top[8*k +: 8] = pick_weight();
                for (int k = 0; k < 3; k++) bot[8*k +: 8] = pick_weight();
                write_reg(ic3_pkg::REG_COEF_TOP, top);
                write_reg(ic3_pkg::REG_COEF_BOT, 48'(bot));
                write_reg(ic3_pkg::REG_OFFSET, 48'(17'($urandom_range(0, 131071))));
                write_reg(ic3_pkg::REG_DIVISOR,
                          $urandom_range(0, 3) == 0 ? 48'($urandom_range(1, 255))
                                                    : 48'($urandom_range(1, 12)));
            end
        endcase
    endtask

    // One frame: every pixel, then the drains that flush it. Noise is mixed in at times:
    // early drains, extra drains after the flush, or the drains left out altogether.
    task automatic run_frame(int w, int h);
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) send_drain();
        for (int i = 0; i < w * h; i++) send_pixel(pick_pixel());
        if (p == 1) return;
        for (int i = 0; i < w + 1; i++) send_drain();
        if (p == 2) send_drain();
    endtask

    // Directed opening: a 3x3 frame through the identity kernel of the reset state, so every
    // result equals its source pixel. No result comes for the first width+1 pixels, the last
    // drain carries tlast, and drains before the frame is complete or after it is flushed
    // give nothing. A new frame is then started without flushing.
    t_row directed [22] = '{
        '{ic3_pkg::OP_DRAIN, 8'd9,   1, 0, 8'd0,   1'b0},
        '{ic3_pkg::OP_PIXEL, 8'd0,   1, 0, 8'd0,   1'b0},
        '{ic3_pkg::OP_PIXEL, 8'd255, 1, 0, 8'd0,   1'b0},
        '{ic3_pkg::OP_PIXEL, 8'd17,  1, 0, 8'd0,   1'b0},
        '{ic3_pkg::OP_PIXEL, 8'd128, 1, 0, 8'd0,   1'b0},
        '{ic3_pkg::OP_PIXEL, 8'd1,   1, 1, 8'd0,   1'b0},
        '{ic3_pkg::OP_PIXEL, 8'd254, 1, 1, 8'd255, 1'b0},
        '{ic3_pkg::OP_DRAIN, 8'd0,   1, 0, 8'd0,   1'b0},
        '{ic3_pkg::OP_PIXEL, 8'd99,  1, 1, 8'd17,  1'b0},
        '{ic3_pkg::OP_PIXEL, 8'd200, 1, 1, 8'd128, 1'b0},
        '{ic3_pkg::OP_PIXEL, 8'd7,   1, 1, 8'd1,   1'b0},
        '{ic3_pkg::OP_DRAIN, 8'd0,   1, 1, 8'd254, 1'b0},
        '{ic3_pkg::OP_DRAIN, 8'd0,   1, 1, 8'd99,  1'b0},
        '{ic3_pkg::OP_DRAIN, 8'd0,   1, 1, 8'd200, 1'b0},
        '{ic3_pkg::OP_DRAIN, 8'd0,   1, 1, 8'd7,   1'b1},
        '{ic3_pkg::OP_DRAIN, 8'd0,   1, 0, 8'd0,   1'b0},
        '{ic3_pkg::OP_PIXEL, 8'd40,  0, 0, 8'd0,   1'b0},
        '{ic3_pkg::OP_PIXEL, 8'd255, 0, 0, 8'd0,   1'b0},
        '{ic3_pkg::OP_PIXEL, 8'd0,   0, 0, 8'd0,   1'b0},
        '{ic3_pkg::OP_PIXEL, 8'd3,   0, 0, 8'd0,   1'b0},
        '{ic3_pkg::OP_PIXEL, 8'd250, 0, 0, 8'd0,   1'b0},
        '{ic3_pkg::OP_PIXEL, 8'd66,  0, 0, 8'd0,   1'b0}
    };

    // Output side: random stalls, mostly short and now and then long.
    initial begin
        int stall;
        stall = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (steady_out || stall == 0) begin
                i_m_tready = 1'b1;
                if (!steady_out && $urandom_range(0, 99) < 30)
                    stall = $urandom_range(0, 9) == 0 ? $urandom_range(10, 60)
                                                      : $urandom_range(1, 3);
            end else begin
                i_m_tready = 1'b0;
                stall--;
            end
        end
    end

    // Every result taken is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (filtered_q.size() == 0) begin
                $display("%0t: unexpected result pixel %0d last %0b", $time, o_m_tdata,
                         o_m_tlast);
                fails++;
            end else begin
                want = filtered_q.pop_front();
                if (o_m_tdata !== want.pix || o_m_tlast !== want.last) begin
                    $display("%0t: expected pixel %0d last %0b, got pixel %0d last %0b",
                             $time, want.pix, want.last, o_m_tdata, o_m_tlast);
                    fails++;
                end
            end
        end
    end

    initial begin
        int w, h, style;
        fails      = 0;
        sent       = 0;
        steady_in  = 1'b0;
        steady_out = 1'b0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;

        // Reset state of the predictor.
        for (int i = 0; i < MAXW; i++) begin
            row_above[i] = '0;
            row_below[i] = '0;
        end
        for (int i = 0; i < 9; i++) window[i] = '0;
        col_pos = 0;
        row_pos = 0;
        backlog = 0;
        w_top   = 48'h0000_0001_0000_0000;
        w_bot   = '0;
        offset  = '0;
        div     = 8'd1;
        width   = 11'd1024;
        height  = 16'd1024;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_reg(ic3_pkg::REG_WIDTH, 48'd3);
        write_reg(ic3_pkg::REG_HEIGHT, 48'd3);
        foreach (directed[i]) send_request(directed[i]);
        wait_idle();

        // Large geometry: a width above the line store acts as the full store. With a
        // single line every pixel passes through; the first few results are drained and
        // the rest are dropped by the next geometry write.
        write_reg(ic3_pkg::REG_WIDTH, 48'd2047);
        write_reg(ic3_pkg::REG_HEIGHT, 48'd1);
        steady_in  = 1'b1;
        steady_out = 1'b1;
        for (int i = 0; i < MAXW; i++) send_pixel(pick_pixel());
        repeat (4) send_drain();
        steady_in  = 1'b0;
        steady_out = 1'b0;
        wait_idle();

        // Zero width and zero height both act as one; the tallest frame is only started.
        write_reg(ic3_pkg::REG_WIDTH, 48'd0);
        write_reg(ic3_pkg::REG_HEIGHT, 48'd0);
        run_frame(1, 1);
        run_frame(1, 1);
        wait_idle();
        write_reg(ic3_pkg::REG_WIDTH, 48'd5);
        write_reg(ic3_pkg::REG_HEIGHT, 48'd65535);
        for (int i = 0; i < 30; i++) send_pixel(pick_pixel());
        send_drain();
        wait_idle();

        // Random phases: fresh settings once the block is idle, then a few small frames.
        style = 0;
        while (sent < 1750) begin
            set_filter(style < 3 ? style : 3);
            style++;
            w = $urandom_range(0, 5) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 8);
            h = $urandom_range(0, 5) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 6);
            if ($urandom_range(0, 3) == 0) w = $urandom_range(20, 40);
            write_reg(ic3_pkg::REG_WIDTH, 48'(w));
            write_reg(ic3_pkg::REG_HEIGHT, 48'(h));
            steady_in  = $urandom_range(0, 4) == 0;
            steady_out = $urandom_range(0, 4) == 0;
            repeat ($urandom_range(1, 3)) begin
                run_frame(w, h);
                // Now and then the sender holds off mid-run until all results are in.
                if ($urandom_range(0, 5) == 0) wait_idle();
            end
            wait_idle();
        end

        wait_idle();
        if (fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ic3_pkg.sv
rtl/ic3_ctrl.sv
rtl/ic3_dp.sv
rtl/image_convolution_3x3.sv
tb/sv/tb_image_convolution_3x3.sv
